@@ rtl/mvn_pkg.sv @@
package mvn_pkg;

	// Coordinate and result geometry
	localparam int CW   = 32;
	localparam int DF   = 30;
	localparam int MW   = CW + 1;
	localparam int SQW  = 2 * MW;
	localparam int SUMW = SQW + 2;
	localparam int LW   = SUMW / 2;
	localparam int SRW  = LW + 2;
	localparam int DRW  = LW + 1;
	localparam int QW   = DF + 1;
	localparam int THRW = 16;
	localparam int LENW = 34;
	localparam int DIRW = 32;
	localparam int INW  = 32;

	// Middle queue depth
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);

	typedef logic [MW-1:0]   mag_t;
	typedef logic [SQW-1:0]  sq_t;
	typedef logic [SUMW-1:0] sum_t;
	typedef logic [LW-1:0]   len_t;
	typedef logic [SRW-1:0]  srem_t;
	typedef logic [DRW-1:0]  drem_t;
	typedef logic [QW-1:0]   quo_t;
	typedef logic [THRW-1:0] thr_t;

	// Item handed from the front to the back
	typedef struct packed {
		sum_t       sxyz;
		sq_t        sq_e;
		mag_t [3:0] mag;
		logic [3:0] neg;
	} mid_t;

	// One digit of the square root: returns {remainder, root}
	function automatic logic [SRW+LW-1:0] sqrt_step(srem_t rem, len_t root, logic [1:0] pair);
		logic [SRW+1:0] r2;
		logic [SRW+1:0] trial;
		srem_t          rem_n;
		len_t           root_n;
		r2    = {rem, pair};
		trial = (SRW+2)'({root, 2'b01});
		if (r2 >= trial) begin
			rem_n  = SRW'(r2 - trial);
			root_n = {root[LW-2:0], 1'b1};
		end else begin
			rem_n  = SRW'(r2);
			root_n = {root[LW-2:0], 1'b0};
		end
		return {rem_n, root_n};
	endfunction

	// One quotient bit: returns {next partial remainder, bit}
	function automatic logic [DRW:0] div_step(drem_t t, len_t len);
		logic  bit_q;
		drem_t r;
		bit_q = (t >= DRW'(len));
		r     = bit_q ? (t - DRW'(len)) : t;
		return {r[DRW-2:0], 1'b0, bit_q};
	endfunction

endpackage

@@ rtl/mvn_front.sv @@
module mvn_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [mvn_pkg::INW-1:0]  start_x,
	input  logic [mvn_pkg::INW-1:0]  start_y,
	input  logic [mvn_pkg::INW-1:0]  start_z,
	input  logic [mvn_pkg::INW-1:0]  start_e,
	input  logic [mvn_pkg::INW-1:0]  end_x,
	input  logic [mvn_pkg::INW-1:0]  end_y,
	input  logic [mvn_pkg::INW-1:0]  end_z,
	input  logic [mvn_pkg::INW-1:0]  end_e,
	output logic                     mid_push,
	output mvn_pkg::mid_t            mid_data,
	input  logic                     mid_full
);
	import mvn_pkg::*;

	logic              en;
	logic              v_s1, v_s2, v_s3;
	logic [INW-1:0]    st [4];
	logic [INW-1:0]    en_pt [4];
	mag_t              mag_s1 [4];
	logic [3:0]        neg_s1, neg_s2, neg_s3;
	sq_t               sq_s2 [4];
	sum_t              sxyz_s3;
	sq_t               sqe_s3;
	mag_t              mag_s2 [4];
	mag_t              mag_s3 [4];

	assign st[0] = start_x;  assign st[1] = start_y;
	assign st[2] = start_z;  assign st[3] = start_e;
	assign en_pt[0] = end_x; assign en_pt[1] = end_y;
	assign en_pt[2] = end_z; assign en_pt[3] = end_e;

	// Advance unless the last stage is blocked by the queue
	assign en       = !v_s3 || !mid_full;
	assign full     = !en;
	assign mid_push = v_s3 && !mid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Difference, sign and magnitude per axis
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				logic signed [MW-1:0] d;
				d = MW'($signed(en_pt[i][CW-1:0])) - MW'($signed(st[i][CW-1:0]));
				neg_s1[i] <= d[MW-1];
				mag_s1[i] <= d[MW-1] ? mag_t'(-d) : mag_t'(d);
			end
		end
	end

	// Squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s2[i]  <= SQW'(mag_s1[i] * mag_s1[i]);
				mag_s2[i] <= mag_s1[i];
			end
			neg_s2 <= neg_s1;
		end
	end

	// XYZ sum, carry the extruder square on
	always_ff @(posedge clk) begin
		if (en) begin
			sxyz_s3 <= SUMW'(sq_s2[0]) + SUMW'(sq_s2[1]) + SUMW'(sq_s2[2]);
			sqe_s3  <= sq_s2[3];
			for (int i = 0; i < 4; i++) mag_s3[i] <= mag_s2[i];
			neg_s3  <= neg_s2;
		end
	end

	always_comb begin
		mid_data.sxyz = sxyz_s3;
		mid_data.sq_e = sqe_s3;
		mid_data.neg  = neg_s3;
		for (int i = 0; i < 4; i++) mid_data.mag[i] = mag_s3[i];
	end

endmodule

@@ rtl/mvn_fifo.sv @@
module mvn_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mvn_pkg::mid_t din,
	output logic          full,
	input  logic          pop,
	output mvn_pkg::mid_t dout,
	output logic          empty
);
	import mvn_pkg::*;

	mid_t             mem_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_q, rd_q;
	logic [FQ_AW:0]   cnt_q;

	assign full  = (cnt_q == (FQ_AW+1)'(FQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	// Store
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= din;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (pop && !empty) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (FQ_AW+1)'(push && !full) - (FQ_AW+1)'(pop && !empty);
		end
	end

endmodule

@@ rtl/mvn_back.sv @@
module mvn_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      mid_empty,
	input  mvn_pkg::mid_t             mid_data,
	output logic                      mid_pop,
	input  logic [mvn_pkg::THRW-1:0]  threshold,
	output logic                      empty,
	input  logic                      pop,
	output logic [mvn_pkg::LENW-1:0]  move_length,
	output logic [mvn_pkg::LENW-1:0]  xyz_length,
	output logic [mvn_pkg::DIRW-1:0]  dir_x,
	output logic [mvn_pkg::DIRW-1:0]  dir_y,
	output logic [mvn_pkg::DIRW-1:0]  dir_z,
	output logic [mvn_pkg::DIRW-1:0]  dir_e,
	output logic                      zero_move
);
	import mvn_pkg::*;

	logic en;
	logic v_out_q;

	// Square-root pipeline, index k holds the state after k digits
	logic       v_sq  [LW+1];
	sum_t       rad4  [LW+1];
	sum_t       radx  [LW+1];
	srem_t      rem4  [LW+1];
	srem_t      remx  [LW+1];
	len_t       root4 [LW+1];
	len_t       rootx [LW+1];
	mag_t [3:0] mag_sq [LW+1];
	logic [3:0] neg_sq [LW+1];

	// Division pipeline, index j holds the state after j quotient bits
	logic        v_dv  [QW+1];
	drem_t [3:0] part  [QW+1];
	quo_t  [3:0] quo   [QW+1];
	len_t        len4  [QW+1];
	len_t        lenx  [QW+1];
	logic [3:0]  neg_dv [QW+1];

	// Whole back end moves when the output slot is free or being taken
	assign en      = !v_out_q || pop;
	assign mid_pop = en && !mid_empty;
	assign empty   = !v_out_q;

	// Entry: finish the four-axis sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sq[0] <= 1'b0;
		else if (en) v_sq[0] <= !mid_empty;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad4[0]   <= mid_data.sxyz + SUMW'(mid_data.sq_e);
			radx[0]   <= mid_data.sxyz;
			rem4[0]   <= '0;
			remx[0]   <= '0;
			root4[0]  <= '0;
			rootx[0]  <= '0;
			mag_sq[0] <= mid_data.mag;
			neg_sq[0] <= mid_data.neg;
		end
	end

	// One root digit per stage for both lengths
	for (genvar k = 0; k < LW; k++) begin : g_sqrt
		logic [SRW+LW-1:0] n4, nx;
		assign n4 = sqrt_step(rem4[k], root4[k], rad4[k][SUMW-1-2*k -: 2]);
		assign nx = sqrt_step(remx[k], rootx[k], radx[k][SUMW-1-2*k -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sq[k+1] <= 1'b0;
			else if (en) v_sq[k+1] <= v_sq[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad4[k+1]   <= rad4[k];
				radx[k+1]   <= radx[k];
				rem4[k+1]   <= n4[SRW+LW-1:LW];
				root4[k+1]  <= n4[LW-1:0];
				remx[k+1]   <= nx[SRW+LW-1:LW];
				rootx[k+1]  <= nx[LW-1:0];
				mag_sq[k+1] <= mag_sq[k];
				neg_sq[k+1] <= neg_sq[k];
			end
		end
	end

	// Hand the magnitudes to the dividers
	always_comb begin
		v_dv[0]   = v_sq[LW];
		len4[0]   = root4[LW];
		lenx[0]   = rootx[LW];
		neg_dv[0] = neg_sq[LW];
		for (int i = 0; i < 4; i++) begin
			part[0][i] = DRW'(mag_sq[LW][i]);
			quo[0][i]  = '0;
		end
	end

	// One quotient bit per stage in each of the four lanes
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [DRW:0] nd [4];
		for (genvar i = 0; i < 4; i++) begin : g_lane
			assign nd[i] = div_step(part[j][i], len4[j]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_dv[j+1] <= 1'b0;
			else if (en) v_dv[j+1] <= v_dv[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 4; i++) begin
					part[j+1][i] <= nd[i][DRW:1];
					quo[j+1][i]  <= {quo[j][i][QW-2:0], nd[i][0]};
				end
				len4[j+1]   <= len4[j];
				lenx[j+1]   <= lenx[j];
				neg_dv[j+1] <= neg_dv[j];
			end
		end
	end

	// Output slot: zero-move test, signs and field widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_q <= 1'b0;
		else if (en) v_out_q <= v_dv[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			logic              zero;
			logic [DIRW-1:0]   dq [4];
			zero = (len4[QW] < LW'(threshold)) || (len4[QW] == '0);
			for (int i = 0; i < 4; i++) begin
				dq[i] = DIRW'(quo[QW][i]);
				if (zero) dq[i] = '0;
				else if (neg_dv[QW][i]) dq[i] = -dq[i];
			end
			move_length <= zero ? '0 : LENW'(len4[QW]);
			xyz_length  <= LENW'(lenx[QW]);
			dir_x       <= dq[0];
			dir_y       <= dq[1];
			dir_z       <= dq[2];
			dir_e       <= dq[3];
			zero_move   <= zero;
		end
	end

endmodule

@@ rtl/move_vector_normalizer_top.sv @@
// Channel   Handshake              Payload
// input     push / full            start_x..start_e, end_x..end_e
// result    empty / pop            move_length, xyz_length, dir_x..dir_e, zero_move
// config    cfg_valid / cfg_ready  cfg_data (zero_length_threshold)
//
// One move enters per cycle while full is low; the front has difference, square and
// sum stages, then comes the queue write, then the back (entry stage, one root digit
// per stage over 34 stages, one quotient bit per stage over 31 stages, output slot).
// A four-entry queue between front and back lets either side stall alone.
// The back end holds all its stages while a result waits unpopped.
// Reset clears all valid flags and sets the threshold to 1; cfg_ready is
// always high.
module move_vector_normalizer_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [mvn_pkg::INW-1:0]   start_x,
	input  logic [mvn_pkg::INW-1:0]   start_y,
	input  logic [mvn_pkg::INW-1:0]   start_z,
	input  logic [mvn_pkg::INW-1:0]   start_e,
	input  logic [mvn_pkg::INW-1:0]   end_x,
	input  logic [mvn_pkg::INW-1:0]   end_y,
	input  logic [mvn_pkg::INW-1:0]   end_z,
	input  logic [mvn_pkg::INW-1:0]   end_e,
	output logic                      empty,
	input  logic                      pop,
	output logic [mvn_pkg::LENW-1:0]  move_length,
	output logic [mvn_pkg::LENW-1:0]  xyz_length,
	output logic [mvn_pkg::DIRW-1:0]  dir_x,
	output logic [mvn_pkg::DIRW-1:0]  dir_y,
	output logic [mvn_pkg::DIRW-1:0]  dir_z,
	output logic [mvn_pkg::DIRW-1:0]  dir_e,
	output logic                      zero_move,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [mvn_pkg::THRW-1:0]  cfg_data
);
	import mvn_pkg::*;

	thr_t threshold_q;
	logic mid_push, mid_full, mid_pop, mid_empty;
	mid_t mid_in, mid_out;

	// Threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) threshold_q <= THRW'(1);
		else if (cfg_valid && cfg_ready) threshold_q <= cfg_data;
	end

	mvn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.start_x  (start_x),
		.start_y  (start_y),
		.start_z  (start_z),
		.start_e  (start_e),
		.end_x    (end_x),
		.end_y    (end_y),
		.end_z    (end_z),
		.end_e    (end_e),
		.mid_push (mid_push),
		.mid_data (mid_in),
		.mid_full (mid_full)
	);

	mvn_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.dout   (mid_out),
		.empty  (mid_empty)
	);

	mvn_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mid_empty   (mid_empty),
		.mid_data    (mid_out),
		.mid_pop     (mid_pop),
		.threshold   (threshold_q),
		.empty       (empty),
		.pop         (pop),
		.move_length (move_length),
		.xyz_length  (xyz_length),
		.dir_x       (dir_x),
		.dir_y       (dir_y),
		.dir_z       (dir_z),
		.dir_e       (dir_e),
		.zero_move   (zero_move)
	);

endmodule
